// ----- hw/rtl/crlm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk RMS level meter package
// Shared sizes, payload types, command and status types and controller states.
// ----------------------------------------------------------------------------
package crlm_pkg;

   localparam int WINDOW     = 1024;
   localparam int SAMPLE_W   = 16;
   localparam int PTR_W      = $clog2(WINDOW);
   localparam int CNT_W      = $clog2(WINDOW + 1);
   localparam int RING_W     = 31;
   localparam int SUM_W      = RING_W + PTR_W;
   localparam int SQ_W       = RING_W + 1;
   localparam int ROOT_W     = SQ_W / 2;
   localparam int GAIN_W     = 10;
   localparam int PROD_W     = ROOT_W + GAIN_W;
   localparam int LEVEL_W    = 16;
   localparam int USED_W     = 11;
   localparam int LVL_SHIFT  = 7;
   localparam int STEP_W     = $clog2(SUM_W + 1);

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(410);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       chunk_end;
   } crlm_req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [USED_W-1:0]  samples_used;
   } crlm_rsp_type;

   typedef struct packed {
      logic take;
      logic square;
      logic accum;
      logic div_init;
      logic div_step;
      logic sqrt_init;
      logic sqrt_step;
      logic scale;
      logic emit;
   } crlm_cmd_type;

   typedef struct packed {
      logic chunk_end;
      logic out_free;
   } crlm_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_DIV_INIT,
      ST_DIV,
      ST_SQRT_INIT,
      ST_SQRT,
      ST_SCALE,
      ST_EMIT
   } crlm_state_type;

endpackage
`default_nettype wire

// ----- hw/rtl/chunk_rms_level_meter.sv -----
// A sample that does not end a chunk is taken, squared and added to the window.
// A sample that ends a chunk then passes the divide, the square root, the scale
// and the emit steps until its word is in the output register.
// Throughput is set by the one-bit-per-cycle divider and square root unit.
// Reset is synchronous and active high; it empties the window and sets the
// gain to 410. The output register lets a new sample in while a word waits.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk RMS level meter
// Mean square over a sliding window per chunk, square root, gain and clamp.
// ----------------------------------------------------------------------------
module chunk_rms_level_meter (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire crlm_pkg::crlm_req_type      req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output crlm_pkg::crlm_rsp_type           rsp_data,
   input  wire logic                        csr_wr_en,
   input  wire logic [crlm_pkg::GAIN_W-1:0] csr_wr_data
);
   import crlm_pkg::*;

   crlm_cmd_type    cmd;
   crlm_status_type status;

   crlm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   crlm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

`ifndef SYNTHESIS
   // Once a word is taken the block is busy with it and not ready at once for the next.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while previous word still in work");

   // A new level must never overwrite a word that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || rsp_ready))
      else $error("result overwritten before it was taken");

   // A result only appears after the controller has emitted one.
   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.emit))
      else $error("result valid without an emit");

   // The square root and divider never run while an input may be taken.
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(cmd.div_step || cmd.sqrt_step || cmd.accum))
      else $error("input ready while datapath busy");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/crlm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk RMS level meter controller
// Sequences the window update, the divide, the square root, the scaling and the output.
// ----------------------------------------------------------------------------
module crlm_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire crlm_pkg::crlm_status_type status,
   output crlm_pkg::crlm_cmd_type         cmd
);
   import crlm_pkg::*;

   crlm_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = status.chunk_end ? ST_DIV_INIT : ST_IDLE;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            step_in      = STEP_W'(SUM_W - 1);
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_SQRT_INIT;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_SQRT_INIT: begin
            cmd.sqrt_init = 1'b1;
            step_in       = STEP_W'(ROOT_W - 1);
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_SCALE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            // Hold the level until the output register has room.
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- hw/rtl/crlm_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk RMS level meter datapath
// Ring of squares, sliding sum, restoring divider, square root and scaling.
// ----------------------------------------------------------------------------
module crlm_datapath (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire crlm_pkg::crlm_cmd_type   cmd,
   output crlm_pkg::crlm_status_type     status,
   input  wire crlm_pkg::crlm_req_type   req_data,
   input  wire logic                     csr_wr_en,
   input  wire logic [crlm_pkg::GAIN_W-1:0] csr_wr_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output crlm_pkg::crlm_rsp_type        rsp_data
);
   import crlm_pkg::*;

   logic [RING_W-1:0] ring [WINDOW];

   logic [GAIN_W-1:0]   gain_ff;
   logic [SAMPLE_W-1:0] mag_ff;
   logic                end_ff;
   logic [RING_W-1:0]   old_ff;
   logic [RING_W-1:0]   sq_ff;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PTR_W-1:0]    ptr_ff, ptr_in;
   logic [SUM_W-1:0]    quo_ff;
   logic [CNT_W-1:0]    rem_ff;
   logic [SQ_W-1:0]     rad_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [ROOT_W+1:0]   srem_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   crlm_rsp_type        rsp_ff;

   logic [SAMPLE_W-1:0] mag_in;
   logic                full;
   logic [CNT_W:0]      div_shift;
   logic                div_ge;
   logic [CNT_W:0]      div_diff;
   logic [ROOT_W+1:0]   sq_shift;
   logic [ROOT_W+1:0]   sq_trial;
   logic                sq_ge;
   logic [LEVEL_W-1:0]  level;

   // The magnitude of the most negative sample still fits as an unsigned value.
   assign mag_in = req_data.sample[SAMPLE_W-1] ? (~req_data.sample + 1'b1)
                                                : req_data.sample;
   assign full   = (count_ff == CNT_W'(WINDOW));

   assign div_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign div_ge    = (div_shift >= {1'b0, count_ff});
   assign div_diff  = div_shift - {1'b0, count_ff};

   assign sq_shift = {srem_ff[ROOT_W-1:0], rad_ff[SQ_W-1:SQ_W-2]};
   assign sq_trial = {root_ff, 2'b01};
   assign sq_ge    = (sq_shift >= sq_trial);

   assign level = (prod_ff[PROD_W-1:LVL_SHIFT+LEVEL_W] != '0) ? '1
                : prod_ff[LVL_SHIFT+LEVEL_W-1:LVL_SHIFT];

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      if (cmd.square) begin
         sum_in = sum_ff - (full ? SUM_W'(old_ff) : '0);
      end else if (cmd.accum) begin
         sum_in   = sum_ff + SUM_W'(sq_ff);
         count_in = full ? count_ff : count_ff + 1'b1;
         ptr_in   = (ptr_ff == PTR_W'(WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
      end else if (cmd.emit) begin
         sum_in   = '0;
         count_in = '0;
         ptr_in   = '0;
      end
      rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_RESET;
         sum_ff       <= '0;
         count_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            gain_ff <= csr_wr_data;
         end
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         old_ff <= ring[ptr_ff];
      end
      if (cmd.accum) begin
         ring[ptr_ff] <= sq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         mag_ff <= mag_in;
         end_ff <= req_data.chunk_end;
      end
      if (cmd.square) begin
         sq_ff <= RING_W'(mag_ff * mag_ff);
      end
      if (cmd.div_init) begin
         quo_ff <= sum_ff;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[SUM_W-2:0], div_ge};
         rem_ff <= div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
      end
      // The mean never exceeds the largest square, so its low bits suffice.
      if (cmd.sqrt_init) begin
         rad_ff  <= SQ_W'(quo_ff[RING_W-1:0]);
         root_ff <= '0;
         srem_ff <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff  <= {rad_ff[SQ_W-3:0], 2'b00};
         root_ff <= {root_ff[ROOT_W-2:0], sq_ge};
         srem_ff <= sq_ge ? (sq_shift - sq_trial) : sq_shift;
      end
      if (cmd.scale) begin
         prod_ff <= root_ff * gain_ff;
      end
      if (cmd.emit) begin
         rsp_ff.level        <= level;
         rsp_ff.samples_used <= USED_W'(count_ff);
      end
   end

   assign status.chunk_end = end_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;

endmodule
`default_nettype wire
